>>> rtl/tshq_pkg.sv
// Shared widths and small helpers for the triangle surface height query block.
// Depends on nothing; used by triangle_surface_height_query.
package tshq_pkg;

  localparam int CW  = 32;           // coordinate width
  localparam int DW  = CW + 1;       // coordinate difference width
  localparam int NW  = 2 * DW + 1;   // normal component / edge value width
  localparam int AW  = NW + DW + 2;  // accumulator and dividend width
  localparam int RW  = NW + 1;       // divider remainder width
  localparam int BDW = CW + 2;       // best distance width
  localparam int CNTW = $clog2(AW);

  // Input transaction opcodes.
  localparam logic OP_BEGIN  = 1'b0;
  localparam logic OP_VERTEX = 1'b1;

  // Difference of two coordinates, exact.
  function automatic logic [DW-1:0] sdiff(input logic [CW-1:0] p, input logic [CW-1:0] q);
    return {p[CW-1], p} - {q[CW-1], q};
  endfunction

  // Sign-extend a difference to the normal width.
  function automatic logic [NW-1:0] sx_nw(input logic [DW-1:0] d);
    return {{(NW - DW){d[DW-1]}}, d};
  endfunction

endpackage

>>> rtl/triangle_surface_height_query.sv
// Top level of the triangle surface height query block.
// Depends on tshq_pkg; contains the sequencer and its shared multiply/divide datapath.
//
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_ready  | opcode, query, reference, mode, vertex, last
//  out     | output    | out_valid / out_ready| answered, found, surface_z
//  cfg     | input     | cfg_wr_en            | enable bit
//
// Begin items and the first two vertices are only stored; one marked last closes the search.
// The third vertex runs up to fourteen bit-serial multiply-accumulates through one shared
// 102-bit adder and a 102-step restoring divide; it stops early when the point is outside
// and skips the divide for a triangle flat in XY.
// Reset is synchronous and active low. The input is not ready while a triangle is
// evaluated, and a second result stalls until the first one in the output register is taken.
module triangle_surface_height_query (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_opcode,
  input  logic [tshq_pkg::CW-1:0] in_query_x,
  input  logic [tshq_pkg::CW-1:0] in_query_y,
  input  logic [tshq_pkg::CW-1:0] in_ref_height,
  input  logic                   in_closest_mode,
  input  logic [tshq_pkg::CW-1:0] in_vertex_x,
  input  logic [tshq_pkg::CW-1:0] in_vertex_y,
  input  logic [tshq_pkg::CW-1:0] in_vertex_z,
  input  logic                   in_last_item,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_answered,
  output logic                   out_found,
  output logic [tshq_pkg::CW-1:0] out_surface_z,
  input  logic                   cfg_wr_en,
  input  logic                   cfg_wr_data
);

  localparam int CW  = tshq_pkg::CW;
  localparam int DW  = tshq_pkg::DW;
  localparam int NW  = tshq_pkg::NW;
  localparam int AW  = tshq_pkg::AW;
  localparam int RW  = tshq_pkg::RW;
  localparam int BDW = tshq_pkg::BDW;
  localparam int CNTW = tshq_pkg::CNTW;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL_LOAD, S_MUL_RUN, S_MUL_POST, S_DIV_PREP, S_DIV_RUN,
    S_DIV_FIX, S_Z_ADD, S_CLAMP, S_DIST, S_UPDATE, S_EMIT
  } state_t;

  typedef enum logic [3:0] {
    M_E0A, M_E0B, M_E1A, M_E1B, M_E2A, M_E2B, M_NZA, M_NZB,
    M_NXA, M_NXB, M_NYA, M_NYB, M_NUMA, M_NUMB
  } mop_t;

  state_t state_r;
  mop_t   op_r;

  logic          enable_r;
  logic [CW-1:0] qx_r, qy_r, ref_r;
  logic          mode_r;
  logic [1:0]    phase_r;
  logic [CW-1:0] ax_r, ay_r, az_r, bx_r, by_r, bz_r, cx_r, cy_r, cz_r;
  logic [CW-1:0] zmin_r, zmax_r, z_r;
  logic [CW-1:0] best_h_r;
  logic [BDW-1:0] best_d_r;
  logic          hit_r, last_r;
  logic          eneg_r, epos_r;
  logic [NW-1:0] nz_r, nx_r, ny_r;
  logic [AW-1:0] acc_r, mc_r, dvd_r;
  logic [DW-1:0] mb_r;
  logic [NW-1:0] den_r;
  logic [RW-1:0] rem_r;
  logic          qneg_r;
  logic [CNTW-1:0] cnt_r;
  logic [DW-1:0] dist_r;

  // Operand selection for the current multiply-accumulate step.
  logic [NW-1:0] a_op;
  logic [DW-1:0] b_op;
  always_comb begin
    a_op = '0;
    b_op = '0;
    case (op_r)
      M_E0A: begin a_op = tshq_pkg::sx_nw(tshq_pkg::sdiff(bx_r, ax_r));
        b_op = tshq_pkg::sdiff(qy_r, ay_r); end
      M_E0B: begin a_op = tshq_pkg::sx_nw(tshq_pkg::sdiff(by_r, ay_r));
        b_op = tshq_pkg::sdiff(qx_r, ax_r); end
      M_E1A: begin a_op = tshq_pkg::sx_nw(tshq_pkg::sdiff(cx_r, bx_r));
        b_op = tshq_pkg::sdiff(qy_r, by_r); end
      M_E1B: begin a_op = tshq_pkg::sx_nw(tshq_pkg::sdiff(cy_r, by_r));
        b_op = tshq_pkg::sdiff(qx_r, bx_r); end
      M_E2A: begin a_op = tshq_pkg::sx_nw(tshq_pkg::sdiff(ax_r, cx_r));
        b_op = tshq_pkg::sdiff(qy_r, cy_r); end
      M_E2B: begin a_op = tshq_pkg::sx_nw(tshq_pkg::sdiff(ay_r, cy_r));
        b_op = tshq_pkg::sdiff(qx_r, cx_r); end
      M_NZA: begin a_op = tshq_pkg::sx_nw(tshq_pkg::sdiff(bx_r, ax_r));
        b_op = tshq_pkg::sdiff(cy_r, ay_r); end
      M_NZB: begin a_op = tshq_pkg::sx_nw(tshq_pkg::sdiff(by_r, ay_r));
        b_op = tshq_pkg::sdiff(cx_r, ax_r); end
      M_NXA: begin a_op = tshq_pkg::sx_nw(tshq_pkg::sdiff(by_r, ay_r));
        b_op = tshq_pkg::sdiff(cz_r, az_r); end
      M_NXB: begin a_op = tshq_pkg::sx_nw(tshq_pkg::sdiff(bz_r, az_r));
        b_op = tshq_pkg::sdiff(cy_r, ay_r); end
      M_NYA: begin a_op = tshq_pkg::sx_nw(tshq_pkg::sdiff(bz_r, az_r));
        b_op = tshq_pkg::sdiff(cx_r, ax_r); end
      M_NYB: begin a_op = tshq_pkg::sx_nw(tshq_pkg::sdiff(bx_r, ax_r));
        b_op = tshq_pkg::sdiff(cz_r, az_r); end
      M_NUMA: begin a_op = nx_r; b_op = tshq_pkg::sdiff(ax_r, qx_r); end
      M_NUMB: begin a_op = ny_r; b_op = tshq_pkg::sdiff(ay_r, qy_r); end
      default: begin a_op = '0; b_op = '0; end
    endcase
  end

  // Second product of each pair is subtracted, except for the numerator pair.
  logic op_neg, op_clr;
  assign op_neg = op_r[0] && (op_r != M_NUMB);
  assign op_clr = !op_r[0];

  // Shared adder of the multiply: the top multiplier bit carries negative weight.
  logic          mul_sub;
  logic [AW-1:0] mul_sum;
  assign mul_sub = op_neg ^ (cnt_r == CNTW'(DW - 1));
  assign mul_sum = acc_r + (mc_r ^ {AW{mul_sub}}) + AW'(mul_sub);

  // Divider compare and subtract.
  logic [RW-1:0] div_trial, div_diff;
  logic          div_ge;
  assign div_trial = {rem_r[RW-2:0], dvd_r[AW-1]};
  assign div_diff  = div_trial - {1'b0, den_r};
  assign div_ge    = !div_diff[RW-1];

  // Edge classification of the accumulator after each edge pair.
  logic acc_neg, acc_pos, eneg_nxt, epos_nxt;
  assign acc_neg  = acc_r[AW-1];
  assign acc_pos  = !acc_r[AW-1] && (acc_r != '0);
  assign eneg_nxt = eneg_r | acc_neg;
  assign epos_nxt = epos_r | acc_pos;

  // Z range of the triangle being accepted.
  logic [CW-1:0] zlo_ab, zhi_ab, zmin_new, zmax_new;
  assign zlo_ab   = ($signed(bz_r) < $signed(az_r)) ? bz_r : az_r;
  assign zhi_ab   = ($signed(bz_r) > $signed(az_r)) ? bz_r : az_r;
  assign zmin_new = ($signed(in_vertex_z) < $signed(zlo_ab)) ? in_vertex_z : zlo_ab;
  assign zmax_new = ($signed(in_vertex_z) > $signed(zhi_ab)) ? in_vertex_z : zhi_ab;

  logic [AW-1:0] zmin_ext, zmax_ext;
  assign zmin_ext = {{(AW - CW){zmin_r[CW-1]}}, zmin_r};
  assign zmax_ext = {{(AW - CW){zmax_r[CW-1]}}, zmax_r};

  logic [DW-1:0] zdiff;
  assign zdiff = tshq_pkg::sdiff(z_r, ref_r);

  logic in_fire, out_free;
  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      op_r      <= M_E0A;
      enable_r  <= 1'b0;
      qx_r      <= '0;
      qy_r      <= '0;
      ref_r     <= '0;
      mode_r    <= 1'b0;
      phase_r   <= '0;
      best_h_r  <= '0;
      best_d_r  <= '1;
      hit_r     <= 1'b0;
      last_r    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        enable_r <= cfg_wr_data;
      end
      if (out_valid && out_ready && !(state_r == S_EMIT && out_free)) begin
        out_valid <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            last_r <= in_last_item;
            if (in_opcode == tshq_pkg::OP_BEGIN) begin
              qx_r     <= in_query_x;
              qy_r     <= in_query_y;
              ref_r    <= in_ref_height;
              mode_r   <= in_closest_mode;
              phase_r  <= '0;
              best_h_r <= '0;
              best_d_r <= '1;
              hit_r    <= 1'b0;
              if (in_last_item) state_r <= S_EMIT;
            end else if (phase_r == 2'd0) begin
              ax_r    <= in_vertex_x;
              ay_r    <= in_vertex_y;
              az_r    <= in_vertex_z;
              phase_r <= 2'd1;
              if (in_last_item) state_r <= S_EMIT;
            end else if (phase_r == 2'd1) begin
              bx_r    <= in_vertex_x;
              by_r    <= in_vertex_y;
              bz_r    <= in_vertex_z;
              phase_r <= 2'd2;
              if (in_last_item) state_r <= S_EMIT;
            end else begin
              cx_r    <= in_vertex_x;
              cy_r    <= in_vertex_y;
              cz_r    <= in_vertex_z;
              zmin_r  <= zmin_new;
              zmax_r  <= zmax_new;
              phase_r <= '0;
              op_r    <= M_E0A;
              eneg_r  <= 1'b0;
              epos_r  <= 1'b0;
              state_r <= S_MUL_LOAD;
            end
          end
        end
        S_MUL_LOAD: begin
          mc_r  <= {{(AW - NW){a_op[NW-1]}}, a_op};
          mb_r  <= b_op;
          cnt_r <= '0;
          if (op_clr) acc_r <= '0;
          state_r <= S_MUL_RUN;
        end
        S_MUL_RUN: begin
          if (mb_r[0]) acc_r <= mul_sum;
          mc_r  <= {mc_r[AW-2:0], 1'b0};
          mb_r  <= {1'b0, mb_r[DW-1:1]};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNTW'(DW - 1)) state_r <= S_MUL_POST;
        end
        S_MUL_POST: begin
          op_r <= mop_t'(op_r + 1'b1);
          case (op_r)
            M_E0B, M_E1B: begin
              eneg_r  <= eneg_nxt;
              epos_r  <= epos_nxt;
              state_r <= S_MUL_LOAD;
            end
            M_E2B: begin
              // Point outside when the edges disagree in sign.
              if (eneg_nxt && epos_nxt) begin
                state_r <= last_r ? S_EMIT : S_IDLE;
              end else begin
                state_r <= S_MUL_LOAD;
              end
            end
            M_NZB: begin
              nz_r    <= acc_r[NW-1:0];
              state_r <= S_MUL_LOAD;
            end
            M_NXB: begin
              nx_r    <= acc_r[NW-1:0];
              state_r <= S_MUL_LOAD;
            end
            M_NYB: begin
              ny_r <= acc_r[NW-1:0];
              if (nz_r == '0) begin
                z_r     <= zmin_r;
                state_r <= S_DIST;
              end else begin
                state_r <= S_MUL_LOAD;
              end
            end
            M_NUMB: state_r <= S_DIV_PREP;
            default: state_r <= S_MUL_LOAD;
          endcase
        end
        S_DIV_PREP: begin
          dvd_r  <= acc_r[AW-1] ? (~acc_r + 1'b1) : acc_r;
          den_r  <= nz_r[NW-1] ? (~nz_r + 1'b1) : nz_r;
          qneg_r <= acc_r[AW-1] ^ nz_r[NW-1];
          rem_r  <= '0;
          cnt_r  <= '0;
          state_r <= S_DIV_RUN;
        end
        S_DIV_RUN: begin
          rem_r <= div_ge ? div_diff : div_trial;
          dvd_r <= {dvd_r[AW-2:0], div_ge};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNTW'(AW - 1)) state_r <= S_DIV_FIX;
        end
        S_DIV_FIX: begin
          acc_r   <= qneg_r ? (~dvd_r + 1'b1) : dvd_r;
          state_r <= S_Z_ADD;
        end
        S_Z_ADD: begin
          acc_r   <= acc_r + {{(AW - CW){az_r[CW-1]}}, az_r};
          state_r <= S_CLAMP;
        end
        S_CLAMP: begin
          if ($signed(acc_r) < $signed(zmin_ext)) z_r <= zmin_r;
          else if ($signed(acc_r) > $signed(zmax_ext)) z_r <= zmax_r;
          else z_r <= acc_r[CW-1:0];
          state_r <= S_DIST;
        end
        S_DIST: begin
          dist_r  <= zdiff[DW-1] ? (~zdiff + 1'b1) : zdiff;
          state_r <= S_UPDATE;
        end
        S_UPDATE: begin
          if (mode_r) begin
            if ({1'b0, dist_r} < best_d_r) begin
              best_d_r <= {1'b0, dist_r};
              best_h_r <= z_r;
              hit_r    <= 1'b1;
            end
          end else if (!hit_r || ($signed(z_r) < $signed(best_h_r))) begin
            best_h_r <= z_r;
            hit_r    <= 1'b1;
          end
          state_r <= last_r ? S_EMIT : S_IDLE;
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid     <= 1'b1;
            out_answered  <= enable_r;
            out_found     <= enable_r && hit_r;
            out_surface_z <= (enable_r && hit_r) ? best_h_r : '0;
            phase_r  <= '0;
            best_h_r <= '0;
            best_d_r <= '1;
            hit_r    <= 1'b0;
            state_r  <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
